// File: hw/rtl/sre_pkg.sv
// Shared types, constants and helpers for the S-record emitter.
// No dependencies; imported by every module of the block.
`default_nettype none

package sre_pkg;

    // Default data bytes per record (legal range 2 to 250)
    localparam int C_RECORD_BYTES = 32;

    // Width that holds the byte countdown over the whole parameter range
    localparam int C_BYTES_W = 8;

    // Longest text one transaction can produce: S2 header, one word, trailer
    localparam int C_MAX_CHARS = 17;
    localparam int C_LEN_W     = 5;
    localparam int C_CHAR_W    = 7;

    // Command codes of the input channel
    localparam logic C_CMD_DATA = 1'b0;
    localparam logic C_CMD_END  = 1'b1;

    // Character codes
    localparam logic [C_CHAR_W-1:0] C_CHAR_S     = 7'h53;
    localparam logic [C_CHAR_W-1:0] C_CHAR_ONE   = 7'h31;
    localparam logic [C_CHAR_W-1:0] C_CHAR_TWO   = 7'h32;
    localparam logic [C_CHAR_W-1:0] C_CHAR_NL    = 7'h0A;
    localparam logic [C_CHAR_W-1:0] C_CHAR_ZERO  = 7'h30;
    localparam logic [C_CHAR_W-1:0] C_CHAR_ALPHA = 7'h37;  // 'A' minus ten

    // Terminator line "S9030000FC" plus newline
    localparam int C_TERM_LEN = 11;
    localparam logic [C_CHAR_W-1:0] C_TERM [C_TERM_LEN] = '{
        7'h53, 7'h39, 7'h30, 7'h33, 7'h30, 7'h30,
        7'h30, 7'h30, 7'h46, 7'h43, 7'h0A
    };

    typedef logic [C_CHAR_W-1:0] t_char;

    // One formatted line of text, handed from the formatter to the serializer
    typedef struct packed {
        logic [C_MAX_CHARS-1:0][C_CHAR_W-1:0] chars;
        logic [C_LEN_W-1:0]                   len;
    } t_line;

    // Uppercase hex digit of one nibble
    function automatic t_char f_hex(input logic [3:0] nib);
        t_char base;
        base = (nib <= 4'd9) ? C_CHAR_ZERO : C_CHAR_ALPHA;
        return base + {3'b000, nib};
    endfunction

endpackage : sre_pkg

`default_nettype wire

// File: hw/rtl/sre_item_if.sv
// Input channel of the S-record emitter: valid/ready plus one item.
// Depends on nothing.
`default_nettype none

interface sre_item_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [15:0] data_word;
    logic [23:0] word_address;

    modport source (output valid, command, data_word, word_address, input ready);
    modport sink   (input valid, command, data_word, word_address, output ready);
endinterface : sre_item_if

`default_nettype wire

// File: hw/rtl/sre_char_if.sv
// Output channel of the S-record emitter: valid/ready plus one character.
// Depends on nothing.
`default_nettype none

interface sre_char_if;
    logic       valid;
    logic       ready;
    logic [6:0] character;
    logic       last;

    modport source (output valid, character, last, input ready);
    modport sink   (input valid, character, last, output ready);
endinterface : sre_char_if

`default_nettype wire

// File: hw/rtl/sre_format.sv
// Record formatter: holds the record countdown and running byte sum and
// turns one input item into a complete line of characters. Uses sre_pkg.
`default_nettype none

module sre_format
    import sre_pkg::*;
#(
    parameter int RECORD_BYTES = C_RECORD_BYTES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_load,
    input  wire logic        i_command,
    input  wire logic [15:0] i_data_word,
    input  wire logic [23:0] i_word_address,
    output t_line            o_line
);

    localparam logic [C_BYTES_W-1:0] RecBytes = C_BYTES_W'(RECORD_BYTES);
    localparam logic [7:0]           CountS1  = 8'((RECORD_BYTES + 3) % 256);
    localparam logic [7:0]           CountS2  = 8'((RECORD_BYTES + 4) % 256);

    logic [C_BYTES_W-1:0] r_bytes_left, n_bytes_left;
    logic [7:0]           r_running_sum, n_running_sum;

    logic                 rec_open;
    logic                 rec_close;
    logic                 is_s2;
    logic [7:0]           count_byte;
    logic [7:0]           addr_hi;
    logic [7:0]           hdr_sum;
    logic [7:0]           line_sum;
    logic [7:0]           check_byte;
    logic [C_LEN_W-1:0]   offs;

    // Decide record boundaries and header type
    assign rec_open   = (r_bytes_left == RecBytes);
    assign rec_close  = (r_bytes_left <= C_BYTES_W'(2));
    assign is_s2      = (i_word_address[23:16] != 8'h00);
    assign count_byte = is_s2 ? CountS2 : CountS1;
    assign addr_hi    = is_s2 ? i_word_address[23:16] : 8'h00;

    // Sum the bytes after the type field
    assign hdr_sum    = count_byte + addr_hi + i_word_address[15:8] + i_word_address[7:0];
    assign line_sum   = (rec_open ? hdr_sum : r_running_sum)
                      + i_data_word[15:8] + i_data_word[7:0];
    assign check_byte = ~line_sum;

    // Lay out header, data digits and trailer
    always_comb begin
        o_line = '0;
        offs   = '0;
        if (i_command == C_CMD_END) begin
            for (int k = 0; k < C_TERM_LEN; k++) begin
                o_line.chars[k] = C_TERM[k];
            end
            o_line.len = C_LEN_W'(C_TERM_LEN);
        end else begin
            if (rec_open) begin
                o_line.chars[0] = C_CHAR_S;
                o_line.chars[1] = is_s2 ? C_CHAR_TWO : C_CHAR_ONE;
                o_line.chars[2] = f_hex(count_byte[7:4]);
                o_line.chars[3] = f_hex(count_byte[3:0]);
                if (is_s2) begin
                    o_line.chars[4] = f_hex(i_word_address[23:20]);
                    o_line.chars[5] = f_hex(i_word_address[19:16]);
                    o_line.chars[6] = f_hex(i_word_address[15:12]);
                    o_line.chars[7] = f_hex(i_word_address[11:8]);
                    o_line.chars[8] = f_hex(i_word_address[7:4]);
                    o_line.chars[9] = f_hex(i_word_address[3:0]);
                    offs = C_LEN_W'(10);
                end else begin
                    o_line.chars[4] = f_hex(i_word_address[15:12]);
                    o_line.chars[5] = f_hex(i_word_address[11:8]);
                    o_line.chars[6] = f_hex(i_word_address[7:4]);
                    o_line.chars[7] = f_hex(i_word_address[3:0]);
                    offs = C_LEN_W'(8);
                end
            end
            o_line.chars[offs]               = f_hex(i_data_word[15:12]);
            o_line.chars[offs + C_LEN_W'(1)] = f_hex(i_data_word[11:8]);
            o_line.chars[offs + C_LEN_W'(2)] = f_hex(i_data_word[7:4]);
            o_line.chars[offs + C_LEN_W'(3)] = f_hex(i_data_word[3:0]);
            if (rec_close) begin
                o_line.chars[offs + C_LEN_W'(4)] = f_hex(check_byte[7:4]);
                o_line.chars[offs + C_LEN_W'(5)] = f_hex(check_byte[3:0]);
                o_line.chars[offs + C_LEN_W'(6)] = C_CHAR_NL;
                o_line.len = offs + C_LEN_W'(7);
            end else begin
                o_line.len = offs + C_LEN_W'(4);
            end
        end
    end

    // Advance the record countdown and running sum
    always_comb begin
        n_bytes_left  = r_bytes_left;
        n_running_sum = r_running_sum;
        if (i_command == C_CMD_END) begin
            n_bytes_left  = RecBytes;
            n_running_sum = 8'h00;
        end else if (rec_close) begin
            n_bytes_left  = RecBytes;
            n_running_sum = 8'h00;
        end else begin
            n_bytes_left  = r_bytes_left - C_BYTES_W'(2);
            n_running_sum = line_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left  <= RecBytes;
            r_running_sum <= 8'h00;
        end else if (i_load) begin
            r_bytes_left  <= n_bytes_left;
            r_running_sum <= n_running_sum;
        end
    end

endmodule : sre_format

`default_nettype wire

// File: hw/rtl/sre_serializer.sv
// Character serializer: holds one formatted line in a shift register and
// sends it one character per transaction. Uses sre_pkg and sre_char_if.
`default_nettype none

module sre_serializer
    import sre_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_load,
    input  wire t_line     i_line,
    output logic           o_free,
    sre_char_if.source     o_result
);

    logic [C_MAX_CHARS-1:0][C_CHAR_W-1:0] r_chars, n_chars;
    logic [C_LEN_W-1:0]                   r_count, n_count;
    logic                                 take;

    assign take            = o_result.valid && o_result.ready;
    assign o_result.valid  = (r_count != '0);
    assign o_result.character = r_chars[0];
    assign o_result.last   = (r_count == C_LEN_W'(1));

    // Free when empty or when the final character leaves this cycle
    assign o_free = (r_count == '0) || (o_result.last && o_result.ready);

    // Load a new line, or shift down one character per transaction
    always_comb begin
        n_chars = r_chars;
        n_count = r_count;
        if (i_load) begin
            n_chars = i_line.chars;
            n_count = i_line.len;
        end else if (take) begin
            n_chars = {C_CHAR_W'(0), r_chars[C_MAX_CHARS-1:1]};
            n_count = r_count - C_LEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_chars <= n_chars;
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule : sre_serializer

`default_nettype wire

// File: hw/rtl/s_record_emitter.sv
// S-record emitter: turns image words into S1/S2/S9 record text.
// Channels: i_item (sink) takes one transaction per item: command, a 16-bit
// data word and its 24-bit load address. o_result (source) gives one ASCII
// character per transaction, with last set on the final character of an item.
// The first character of an item is offered in the cycle after the
// item is accepted. Each item yields 4 characters, plus 8 (S1) or 10 (S2)
// header characters when a record opens and 3 trailer characters when it
// closes; an end command yields the 11-character S9 line. One character
// leaves the output shift register per cycle while the receiver is ready,
// so an item yields 4 to 17 characters.
// A new item is accepted in the same cycle in which the final character of
// the previous one is taken, so there is no gap between lines.
// When the receiver stalls, the current character holds and no new item is
// accepted until the line drains. Reset empties the output and closes any
// open record, so the next data word opens a new one; the input is not ready
// while reset is held.
// Depends on sre_pkg, sre_item_if, sre_char_if, sre_format, sre_serializer.
`default_nettype none

module s_record_emitter
    import sre_pkg::*;
#(
    parameter int RECORD_BYTES = C_RECORD_BYTES
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sre_item_if.sink   i_item,
    sre_char_if.source o_result
);

    logic  ser_free;
    logic  load;
    t_line line;

    // Accept a transaction whenever the serializer can take a new line
    assign i_item.ready = ser_free && i_rst_n;
    assign load         = i_item.valid && i_item.ready;

    sre_format #(
        .RECORD_BYTES (RECORD_BYTES)
    ) u_format (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (load),
        .i_command      (i_item.command),
        .i_data_word    (i_item.data_word),
        .i_word_address (i_item.word_address),
        .o_line         (line)
    );

    sre_serializer u_serializer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_line   (line),
        .o_free   (ser_free),
        .o_result (o_result)
    );

endmodule : s_record_emitter

`default_nettype wire

// File: dv/tb_s_record_emitter.sv
// Self-checking testbench for s_record_emitter: drives image words and end
// commands, predicts the S-record text and checks every character and last.
// Depends on sre_pkg, sre_item_if, sre_char_if and the s_record_emitter RTL.
`timescale 1ns / 1ps

module tb_s_record_emitter;
    import sre_pkg::*;

    localparam int REC_BYTES   = C_RECORD_BYTES;
    localparam int RANDOM_ITEMS = 320;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        t_char character;
        logic  last;
    } t_text_char;

    typedef struct {
        logic        cmd;
        logic [15:0] word;
        logic [23:0] addr;
        string       text;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    sre_item_if item_ch ();
    sre_char_if char_ch ();

    s_record_emitter #(
        .RECORD_BYTES(REC_BYTES)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (char_ch)
    );

    // Record state mirrored by the predictor
    int         bytes_to_go = REC_BYTES;
    logic [7:0] record_sum  = 8'h00;

    t_text_char line_buf[$];
    t_text_char pending_text[$];
    t_stim_row  directed_rows[$];

    int errors      = 0;
    int cycle_count = 0;
    bit calm        = 1'b0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Cap the run length
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d characters outstanding", $time,
                     pending_text.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic void put_char(t_char ch);
        line_buf.push_back('{character: ch, last: 1'b0});
    endfunction

    function automatic t_char hex_digit(logic [3:0] nib);
        if (nib < 4'd10)
            return C_CHAR_ZERO + t_char'(nib);
        return C_CHAR_ALPHA + t_char'(nib);
    endfunction

    function automatic void put_byte(logic [7:0] b);
        record_sum = record_sum + b;
        put_char(hex_digit(b[7:4]));
        put_char(hex_digit(b[3:0]));
    endfunction

    // Build the text one transaction produces and advance the record state
    function automatic void predict_line(logic cmd, logic [15:0] word, logic [23:0] addr);
        line_buf.delete();
        if (cmd == C_CMD_END) begin
            for (int k = 0; k < C_TERM_LEN; k++)
                put_char(C_TERM[k]);
            bytes_to_go = REC_BYTES;
            record_sum  = 8'h00;
        end else begin
            if (bytes_to_go == REC_BYTES) begin
                record_sum = 8'h00;
                put_char(C_CHAR_S);
                if (addr[23:16] != 8'h00) begin
                    put_char(C_CHAR_TWO);
                    put_byte(8'(REC_BYTES + 4));
                    put_byte(addr[23:16]);
                end else begin
                    put_char(C_CHAR_ONE);
                    put_byte(8'(REC_BYTES + 3));
                end
                put_byte(addr[15:8]);
                put_byte(addr[7:0]);
            end
            put_byte(word[15:8]);
            put_byte(word[7:0]);
            if (bytes_to_go <= 2) begin
                put_byte(~record_sum);
                put_char(C_CHAR_NL);
                bytes_to_go = REC_BYTES;
            end else begin
                bytes_to_go = bytes_to_go - 2;
            end
        end
        if (line_buf.size() > 0)
            line_buf[line_buf.size() - 1].last = 1'b1;
    endfunction

    // Offer one transaction, wait for acceptance, queue its expected text
    task automatic send_item(logic cmd, logic [15:0] word, logic [23:0] addr, string text);
        while (!calm && $urandom_range(0, 99) < 23) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.command      <= cmd;
        item_ch.data_word    <= word;
        item_ch.word_address <= addr;
        @(posedge i_clk);
        while (!item_ch.ready)
            @(posedge i_clk);
        predict_line(cmd, word, addr);
        if (text.len() != 0) begin
            for (int k = 0; k < text.len(); k++)
                pending_text.push_back('{character: t_char'(text[k]),
                                         last: (k == text.len() - 1)});
        end else begin
            foreach (line_buf[k])
                pending_text.push_back(line_buf[k]);
        end
    endtask

    // Receiver: stall at random outside the calm stretch
    initial begin
        char_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            char_ch.ready <= i_rst_n && (calm || $urandom_range(0, 99) >= 23);
        end
    end

    // Check each character against the oldest expectation
    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n && char_ch.valid && char_ch.ready) begin
            if (pending_text.size() == 0) begin
                $display("%0t: unexpected character expected none actual %h last %b",
                         $time, char_ch.character, char_ch.last);
                errors++;
            end else begin
                want = pending_text.pop_front();
                if (char_ch.character !== want.character) begin
                    $display("%0t: character expected %h actual %h", $time,
                             want.character, char_ch.character);
                    errors++;
                end
                if (char_ch.last !== want.last) begin
                    $display("%0t: last expected %b actual %b", $time,
                             want.last, char_ch.last);
                    errors++;
                end
            end
        end
    end

    // Stimulus
    initial begin
        logic [23:0] next_addr;
        logic [15:0] word;
        int          pick;

        i_rst_n              <= 1'b0;
        item_ch.valid        <= 1'b0;
        item_ch.command      <= C_CMD_DATA;
        item_ch.data_word    <= 16'h0000;
        item_ch.word_address <= 24'h000000;
        next_addr = 24'h000000;

        // Directed table: terminator alone and inside a record, S1/S2 extremes,
        // a full record with checksum, and the S1/S2 address boundary
        directed_rows.push_back('{C_CMD_END,  16'h0000, 24'h000000, "S9030000FC\n"});
        directed_rows.push_back('{C_CMD_DATA, 16'h0000, 24'h000000, "S12300000000"});
        directed_rows.push_back('{C_CMD_END,  16'hFFFF, 24'hFFFFFF, "S9030000FC\n"});
        directed_rows.push_back('{C_CMD_DATA, 16'hFFFF, 24'hFFFFFF, "S224FFFFFFFFFF"});
        directed_rows.push_back('{C_CMD_DATA, 16'h0123, 24'h000000, ""});
        directed_rows.push_back('{C_CMD_DATA, 16'h4567, 24'h000000, ""});
        directed_rows.push_back('{C_CMD_DATA, 16'h89AB, 24'h000000, ""});
        directed_rows.push_back('{C_CMD_DATA, 16'hCDEF, 24'h000000, ""});
        directed_rows.push_back('{C_CMD_DATA, 16'hFEDC, 24'h000000, ""});
        directed_rows.push_back('{C_CMD_DATA, 16'hBA98, 24'h000000, ""});
        directed_rows.push_back('{C_CMD_DATA, 16'h7654, 24'h000000, ""});
        directed_rows.push_back('{C_CMD_DATA, 16'h3210, 24'h000000, ""});
        directed_rows.push_back('{C_CMD_DATA, 16'h8000, 24'h000000, ""});
        directed_rows.push_back('{C_CMD_DATA, 16'h0001, 24'h000000, ""});
        directed_rows.push_back('{C_CMD_DATA, 16'h00FF, 24'h000000, ""});
        directed_rows.push_back('{C_CMD_DATA, 16'hFF00, 24'h000000, ""});
        directed_rows.push_back('{C_CMD_DATA, 16'h5A5A, 24'h000000, ""});
        directed_rows.push_back('{C_CMD_DATA, 16'hA5A5, 24'h000000, ""});
        directed_rows.push_back('{C_CMD_DATA, 16'h1234, 24'h000000, ""});
        directed_rows.push_back('{C_CMD_DATA, 16'hFFFF, 24'h00FFFF, ""});
        directed_rows.push_back('{C_CMD_END,  16'h0000, 24'h000000, "S9030000FC\n"});
        directed_rows.push_back('{C_CMD_DATA, 16'h0000, 24'h010000, "S2240100000000"});
        directed_rows.push_back('{C_CMD_END,  16'h5555, 24'hAAAAAA, "S9030000FC\n"});

        // Hold reset
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r])
            send_item(directed_rows[r].cmd, directed_rows[r].word,
                      directed_rows[r].addr, directed_rows[r].text);

        // Random part: mostly whole records at running addresses, some noise
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= 120 && n < 200);
            if ($urandom_range(0, 99) < 4) begin
                send_item(C_CMD_END, 16'($urandom), 24'($urandom), "");
            end else begin
                if (bytes_to_go == REC_BYTES) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 25)
                        next_addr = 24'($urandom_range(0, 16'hFFFF));
                    else if (pick < 35)
                        next_addr = 24'h000000;
                    else if (pick < 45)
                        next_addr = 24'hFFFFFF;
                    else
                        next_addr = 24'($urandom);
                end else if ($urandom_range(0, 99) < 5) begin
                    next_addr = 24'($urandom);
                end
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    word = 16'h0000;
                else if (pick < 15)
                    word = 16'hFFFF;
                else
                    word = 16'($urandom);
                send_item(C_CMD_DATA, word, next_addr, "");
                next_addr = next_addr + 24'd2;
            end
        end
        calm = 1'b0;
        item_ch.valid <= 1'b0;

        // Drain outstanding text, then watch for stray characters
        while (pending_text.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule : tb_s_record_emitter
